>>> sv/local_box_mean_sd_3d_core_assert.svh
// assertion macros used by the checker file
`ifndef LOCAL_BOX_MEAN_SD_3D_CORE_ASSERT_SVH
`define LOCAL_BOX_MEAN_SD_3D_CORE_ASSERT_SVH

// clocked on clk, quiet while arst_n is low
`define LBX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked on clk, also checked during reset
`define LBX_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/lbx_pkg.sv
// shared types and constants of the local box mean and sd block
`default_nettype none
package lbx_pkg;

	localparam int DEF_MAX_X       = 64;
	localparam int DEF_MAX_Y       = 64;
	localparam int DEF_MAX_Z       = 16;
	localparam int DEF_MAX_RADIUS  = 3;
	localparam int DEF_SAMPLE_BITS = 16;

	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int VALUE_W   = 24;
	localparam int COUNT_W   = 9;
	localparam int SMP_W     = 16;
	localparam int CM_W      = 24;
	localparam int X_W       = 7;
	localparam int Y_W       = 7;
	localparam int Z_W       = 5;
	localparam int R_W       = 3;
	localparam int ACC_W     = 64;

	localparam logic [6:0] SIZE_X_RST = 7'd64;
	localparam logic [6:0] SIZE_Y_RST = 7'd64;
	localparam logic [4:0] SIZE_Z_RST = 5'd16;
	localparam logic [1:0] RADIUS_RST = 2'd1;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_MEAN  = 2'd1,
		CMD_SD    = 2'd2,
		CMD_BAD   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_SIZE_X = 2'd0,
		REG_SIZE_Y = 2'd1,
		REG_SIZE_Z = 2'd2,
		REG_RADIUS = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		K_IGN   = 2'd0,
		K_WRITE = 2'd1,
		K_MEAN  = 2'd2,
		K_SD    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [X_W-1:0]   x;
		logic [Y_W-1:0]   y;
		logic [Z_W-1:0]   z;
		logic [X_W-1:0]   xs;
		logic [X_W-1:0]   xe;
		logic [Y_W-1:0]   ys;
		logic [Y_W-1:0]   ye;
		logic [Z_W-1:0]   zs;
		logic [Z_W-1:0]   ze;
		logic [SMP_W-1:0] sample;
		logic [CM_W-1:0]  cm;
	} op_t;

endpackage
`default_nettype wire

>>> sv/local_box_mean_sd_3d_core.sv
// top level of the local box mean and standard deviation block
//
// channel   direction  handshake              payload
// input     in         push / full            cmd pos_x pos_y pos_z sample center_mean
// result    out        empty / pop            value count status
// config    in         cfg_we                 cfg_index cfg_data
//
// a write or an ignored item goes through the back end as a queue pop, then a result load
// a query is popped from the queue, makes n window reads (n up to 343, one ram read per
// cycle), drains the read pipe, then runs the division and, for sd, the square root, before
// the result load
// a two-entry queue lets the front take items while the back end is busy
// the result register holds a finished result while the next item is worked on
// arst_n clears control state; voxel memory holds garbage until written
`default_nettype none
module local_box_mean_sd_3d_core #(
	parameter int MAX_X       = lbx_pkg::DEF_MAX_X,
	parameter int MAX_Y       = lbx_pkg::DEF_MAX_Y,
	parameter int MAX_Z       = lbx_pkg::DEF_MAX_Z,
	parameter int MAX_RADIUS  = lbx_pkg::DEF_MAX_RADIUS,
	parameter int SAMPLE_BITS = lbx_pkg::DEF_SAMPLE_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lbx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lbx_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [1:0]                    cmd,
	input  wire logic [5:0]                    pos_x,
	input  wire logic [5:0]                    pos_y,
	input  wire logic [3:0]                    pos_z,
	input  wire logic [15:0]                   sample,
	input  wire logic [23:0]                   center_mean,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [lbx_pkg::VALUE_W-1:0]        value,
	output logic [lbx_pkg::COUNT_W-1:0]        count,
	output logic                               status
);
	localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	lbx_pkg::op_t           op_in, q_head;
	logic                   q_empty, q_pop;
	logic                   ram_we;
	logic [AW-1:0]          ram_addr;
	logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

	lbx_front #(
		.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z), .MAX_RADIUS(MAX_RADIUS)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.sample(sample), .center_mean(center_mean),
		.op(op_in)
	);

	lbx_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .din(op_in), .full(full),
		.pop(q_pop), .empty(q_empty), .dout(q_head)
	);

	lbx_ram #(.W(SAMPLE_BITS), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	lbx_back #(
		.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z), .SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
		.ram_we(ram_we), .ram_addr(ram_addr), .ram_wdata(ram_wdata), .ram_rdata(ram_rdata),
		.pop(pop), .empty(empty), .value(value), .count(count), .status(status)
	);
endmodule
`default_nettype wire

>>> sv/lbx_ram.sv
// generic single-port ram with registered read
`default_nettype none
module lbx_ram #(
	parameter int W     = 16,
	parameter int DEPTH = 1024,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] addr,
	input  wire logic [W-1:0]  wdata,
	output logic      [W-1:0]  rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

>>> sv/lbx_fifo.sv
// two-entry queue of decoded operations between front and back
`default_nettype none
module lbx_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire lbx_pkg::op_t  din,
	output logic               full,
	input  wire logic          pop,
	output logic               empty,
	output lbx_pkg::op_t       dout
);
	lbx_pkg::op_t ent_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   fill_q;

	assign full  = (fill_q == 2'd2);
	assign empty = (fill_q == 2'd0);
	assign dout  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wp_q <= ~wp_q;
			end
			if (pop && !empty) begin
				rp_q <= ~rp_q;
			end
			if ((push && !full) && !(pop && !empty)) begin
				fill_q <= fill_q + 2'd1;
			end else if (!(push && !full) && (pop && !empty)) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wp_q] <= din;
		end
	end
endmodule
`default_nettype wire

>>> sv/lbx_front.sv
// front end: configuration registers, range check and window bounds
`default_nettype none
module lbx_front #(
	parameter int MAX_X      = lbx_pkg::DEF_MAX_X,
	parameter int MAX_Y      = lbx_pkg::DEF_MAX_Y,
	parameter int MAX_Z      = lbx_pkg::DEF_MAX_Z,
	parameter int MAX_RADIUS = lbx_pkg::DEF_MAX_RADIUS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lbx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lbx_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic [1:0]                    cmd,
	input  wire logic [5:0]                    pos_x,
	input  wire logic [5:0]                    pos_y,
	input  wire logic [3:0]                    pos_z,
	input  wire logic [15:0]                   sample,
	input  wire logic [23:0]                   center_mean,
	output lbx_pkg::op_t                       op
);
	logic [6:0] size_x_q;
	logic [6:0] size_y_q;
	logic [4:0] size_z_q;
	logic [1:0] radius_q;

	logic [6:0] sx, sy, px, py, xe_raw, ye_raw;
	logic [4:0] sz, pz, ze_raw;
	logic [2:0] rr;
	logic       ign;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= lbx_pkg::SIZE_X_RST;
			size_y_q <= lbx_pkg::SIZE_Y_RST;
			size_z_q <= lbx_pkg::SIZE_Z_RST;
			radius_q <= lbx_pkg::RADIUS_RST;
		end else if (cfg_we) begin
			case (lbx_pkg::reg_idx_t'(cfg_index))
				lbx_pkg::REG_SIZE_X: size_x_q <= cfg_data;
				lbx_pkg::REG_SIZE_Y: size_y_q <= cfg_data;
				lbx_pkg::REG_SIZE_Z: size_z_q <= cfg_data[4:0];
				lbx_pkg::REG_RADIUS: radius_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// sizes and radius clamp to the built maximum
	always_comb begin
		sx = (32'(size_x_q) > MAX_X) ? 7'(MAX_X) : size_x_q;
		sy = (32'(size_y_q) > MAX_Y) ? 7'(MAX_Y) : size_y_q;
		sz = (32'(size_z_q) > MAX_Z) ? 5'(MAX_Z) : size_z_q;
		rr = (32'(radius_q) > MAX_RADIUS) ? 3'(MAX_RADIUS) : {1'b0, radius_q};
		px = {1'b0, pos_x};
		py = {1'b0, pos_y};
		pz = {1'b0, pos_z};
		ign = (cmd == lbx_pkg::CMD_BAD) || (px >= sx) || (py >= sy) || (pz >= sz);

		xe_raw = px + {4'd0, rr};
		ye_raw = py + {4'd0, rr};
		ze_raw = pz + {2'd0, rr};

		op.x      = px;
		op.y      = py;
		op.z      = pz;
		op.xs     = (px >= {4'd0, rr}) ? px - {4'd0, rr} : 7'd0;
		op.ys     = (py >= {4'd0, rr}) ? py - {4'd0, rr} : 7'd0;
		op.zs     = (pz >= {2'd0, rr}) ? pz - {2'd0, rr} : 5'd0;
		op.xe     = (xe_raw > sx - 7'd1) ? sx - 7'd1 : xe_raw;
		op.ye     = (ye_raw > sy - 7'd1) ? sy - 7'd1 : ye_raw;
		op.ze     = (ze_raw > sz - 5'd1) ? sz - 5'd1 : ze_raw;
		op.sample = sample;
		op.cm     = center_mean;
		if (ign) begin
			op.kind = lbx_pkg::K_IGN;
		end else begin
			case (lbx_pkg::cmd_t'(cmd))
				lbx_pkg::CMD_WRITE: op.kind = lbx_pkg::K_WRITE;
				lbx_pkg::CMD_MEAN:  op.kind = lbx_pkg::K_MEAN;
				lbx_pkg::CMD_SD:    op.kind = lbx_pkg::K_SD;
				default:            op.kind = lbx_pkg::K_IGN;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> sv/lbx_back.sv
// back end: window walk, accumulate, divide, square root and result register
`default_nettype none
module lbx_back #(
	parameter int MAX_X       = lbx_pkg::DEF_MAX_X,
	parameter int MAX_Y       = lbx_pkg::DEF_MAX_Y,
	parameter int MAX_Z       = lbx_pkg::DEF_MAX_Z,
	parameter int SAMPLE_BITS = lbx_pkg::DEF_SAMPLE_BITS,
	localparam int DEPTH      = MAX_X * MAX_Y * MAX_Z,
	localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_empty,
	input  wire lbx_pkg::op_t                q_head,
	output logic                             q_pop,
	output logic                             ram_we,
	output logic [AW-1:0]                    ram_addr,
	output logic [SAMPLE_BITS-1:0]           ram_wdata,
	input  wire logic [SAMPLE_BITS-1:0]      ram_rdata,
	input  wire logic                        pop,
	output logic                             empty,
	output logic [lbx_pkg::VALUE_W-1:0]      value,
	output logic [lbx_pkg::COUNT_W-1:0]      count,
	output logic                             status
);
	localparam int DW    = (SAMPLE_BITS + 8 > lbx_pkg::CM_W) ? SAMPLE_BITS + 8 : lbx_pkg::CM_W;
	localparam int ACC_W = lbx_pkg::ACC_W;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_WALK  = 6'b000010,
		S_DRAIN = 6'b000100,
		S_DIV   = 6'b001000,
		S_SQRT  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	lbx_pkg::op_t op_q;
	logic [lbx_pkg::X_W-1:0] x_q;
	logic [lbx_pkg::Y_W-1:0] y_q;
	logic [lbx_pkg::Z_W-1:0] z_q;
	logic [lbx_pkg::COUNT_W-1:0] cnt_q;
	logic v_s1, v_s2, v_s3;
	logic [DW-1:0] d_s2;
	logic [ACC_W-1:0] sq_s3;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] n_q;
	logic [lbx_pkg::COUNT_W-1:0] rem_q;
	logic [6:0] step_q;
	logic [ACC_W-1:0] root_q;
	logic [ACC_W-1:0] bit_q;
	logic [lbx_pkg::VALUE_W-1:0] res_val_q;
	logic res_st_q;
	logic [lbx_pkg::VALUE_W-1:0] val_q;
	logic [lbx_pkg::COUNT_W-1:0] ocnt_q;
	logic ost_q;
	logic ov_q;

	logic is_mean;
	logic last;
	logic load_out;
	logic [DW-1:0] s_ext, cm_ext, diff;
	logic [2*DW-1:0] prod;
	logic [ACC_W:0] acc_sum;
	logic [lbx_pkg::COUNT_W:0] r2;
	logic [ACC_W-1:0] sq_t;

	assign is_mean  = (op_q.kind == lbx_pkg::K_MEAN);
	assign last     = (x_q == op_q.xe) && (y_q == op_q.ye) && (z_q == op_q.ze);
	assign q_pop    = state_q[0] && !q_empty;
	assign load_out = (state_q == S_DONE) && (!ov_q || pop);
	assign ram_we   = q_pop && (q_head.kind == lbx_pkg::K_WRITE);
	assign ram_wdata = SAMPLE_BITS'(q_head.sample);

	always_comb begin
		if (state_q == S_WALK) begin
			ram_addr = AW'((32'(z_q) * MAX_Y + 32'(y_q)) * MAX_X + 32'(x_q));
		end else begin
			ram_addr = AW'((32'(q_head.z) * MAX_Y + 32'(q_head.y)) * MAX_X + 32'(q_head.x));
		end
		s_ext   = DW'({ram_rdata, 8'd0});
		cm_ext  = DW'(op_q.cm);
		diff    = (s_ext >= cm_ext) ? s_ext - cm_ext : cm_ext - s_ext;
		prod    = d_s2 * d_s2;
		acc_sum = {1'b0, acc_q} + {1'b0, sq_s3};
		r2      = {rem_q, n_q[ACC_W-1]};
		sq_t    = root_q + bit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_WALK);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						if (q_head.kind == lbx_pkg::K_MEAN || q_head.kind == lbx_pkg::K_SD) begin
							state_q <= S_WALK;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_WALK:  if (last) state_q <= S_DRAIN;
				S_DRAIN: if (!v_s1 && !v_s2 && !v_s3) state_q <= S_DIV;
				S_DIV: begin
					if (step_q == 7'd63) begin
						state_q <= is_mean ? S_DONE : S_SQRT;
					end
				end
				S_SQRT:  if (step_q == 7'd31) state_q <= S_DONE;
				S_DONE:  if (load_out) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		// datapath pipe: read data, deviation, square
		d_s2  <= is_mean ? DW'(ram_rdata) : diff;
		sq_s3 <= is_mean ? ACC_W'(d_s2) : ACC_W'(prod);
		if (v_s3) begin
			acc_q <= acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
		end
		case (state_q)
			S_IDLE: begin
				op_q      <= q_head;
				x_q       <= q_head.xs;
				y_q       <= q_head.ys;
				z_q       <= q_head.zs;
				cnt_q     <= '0;
				acc_q     <= '0;
				res_val_q <= '0;
				res_st_q  <= (q_head.kind == lbx_pkg::K_IGN);
			end
			S_WALK: begin
				cnt_q <= cnt_q + 1'b1;
				if (x_q == op_q.xe) begin
					x_q <= op_q.xs;
					if (y_q == op_q.ye) begin
						y_q <= op_q.ys;
						z_q <= z_q + 1'b1;
					end else begin
						y_q <= y_q + 1'b1;
					end
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
			S_DRAIN: begin
				n_q    <= is_mean ? {acc_q[ACC_W-9:0], 8'd0} : acc_q;
				rem_q  <= '0;
				step_q <= '0;
			end
			S_DIV: begin
				// restoring division, one quotient bit per cycle
				if (r2 >= {1'b0, cnt_q}) begin
					rem_q <= lbx_pkg::COUNT_W'(r2 - {1'b0, cnt_q});
					n_q   <= {n_q[ACC_W-2:0], 1'b1};
				end else begin
					rem_q <= r2[lbx_pkg::COUNT_W-1:0];
					n_q   <= {n_q[ACC_W-2:0], 1'b0};
				end
				step_q <= step_q + 7'd1;
				if (step_q == 7'd63) begin
					step_q <= '0;
					root_q <= '0;
					bit_q  <= {2'b01, {(ACC_W-2){1'b0}}};
					if (r2 >= {1'b0, cnt_q}) begin
						res_val_q <= (|n_q[ACC_W-2:lbx_pkg::VALUE_W-1]) ? {lbx_pkg::VALUE_W{1'b1}}
							: {n_q[lbx_pkg::VALUE_W-2:0], 1'b1};
					end else begin
						res_val_q <= (|n_q[ACC_W-2:lbx_pkg::VALUE_W-1]) ? {lbx_pkg::VALUE_W{1'b1}}
							: {n_q[lbx_pkg::VALUE_W-2:0], 1'b0};
					end
				end
			end
			S_SQRT: begin
				// two radicand bits per cycle
				if (n_q >= sq_t) begin
					n_q    <= n_q - sq_t;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q  <= bit_q >> 2;
				step_q <= step_q + 7'd1;
			end
			default: ;
		endcase
		if (load_out) begin
			// sd takes the finished root, everything else the registered result
			if (op_q.kind == lbx_pkg::K_SD) begin
				val_q <= (|root_q[ACC_W-1:lbx_pkg::VALUE_W]) ? {lbx_pkg::VALUE_W{1'b1}}
					: root_q[lbx_pkg::VALUE_W-1:0];
			end else begin
				val_q <= res_val_q;
			end
			ocnt_q <= cnt_q;
			ost_q  <= res_st_q;
		end
	end

	assign empty  = !ov_q;
	assign value  = val_q;
	assign count  = ocnt_q;
	assign status = ost_q;
endmodule
`default_nettype wire

>>> sv/lbx_checker.sv
// port-level checker for the local box mean and sd block, with its bind
`default_nettype none
`include "local_box_mean_sd_3d_core_assert.svh"
module lbx_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          empty,
	input wire logic                          pop,
	input wire logic [lbx_pkg::VALUE_W-1:0]   value,
	input wire logic [lbx_pkg::COUNT_W-1:0]   count,
	input wire logic                          status
);
	`LBX_ASSERT_RST(a_rst_empty, !arst_n |-> empty, "result shown during reset")
	`LBX_ASSERT(a_ign_zero, !empty && status |-> count == 0 && value == 0, "ignored item with data")
	`LBX_ASSERT(a_write_zero, !empty && count == 0 |-> value == 0, "write result with a value")
	`LBX_ASSERT(a_cnt_max, !empty |-> count <= 9'd343, "window count too large")
	`LBX_ASSERT(a_hold, !empty && !pop |=> !empty && $stable(value) && $stable(count), "result lost")
endmodule

bind local_box_mean_sd_3d_core lbx_checker u_lbx_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.value(value), .count(count), .status(status)
);
`default_nettype wire

>>> sim/local_box_mean_sd_3d_core_tb.sv
// testbench for local_box_mean_sd_3d_core: directed table, then random traffic checked by a predictor
`timescale 1ns / 100ps
`default_nettype none
module local_box_mean_sd_3d_core_tb;

	localparam int HOLD_CYCLES = 3000;
	localparam int IDLE_LIMIT  = 20000;
	localparam int DRAIN_WAIT  = 500;
	localparam int PHASE_ITEMS = 250;

	typedef struct {
		logic [lbx_pkg::VALUE_W-1:0] value;
		logic [lbx_pkg::COUNT_W-1:0] count;
		logic                        status;
	} box_res_t;

	typedef struct {
		lbx_pkg::cmd_t c;
		logic [5:0]    x;
		logic [5:0]    y;
		logic [3:0]    z;
		logic [15:0]   smp;
		logic [23:0]   cm;
		bit            typed;
		box_res_t      res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [lbx_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [lbx_pkg::CFG_W-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [1:0] cmd = '0;
	logic [5:0] pos_x = '0;
	logic [5:0] pos_y = '0;
	logic [3:0] pos_z = '0;
	logic [15:0] sample = '0;
	logic [23:0] center_mean = '0;
	logic full, empty, status;
	logic [lbx_pkg::VALUE_W-1:0] value;
	logic [lbx_pkg::COUNT_W-1:0] count;

	local_box_mean_sd_3d_core u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full), .cmd(cmd),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.sample(sample), .center_mean(center_mean),
		.empty(empty), .pop(pop), .value(value), .count(count), .status(status)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// predictor state
	logic [15:0] voxels [0:65535];
	bit          voxel_set [0:65535];
	int unsigned dim_x = 64, dim_y = 64, dim_z = 16, win_r = 1;
	box_res_t    pending_q [$];
	int          errors = 0;
	bit          hold_req = 1'b0;

	function automatic int vaddr(int x, int y, int z);
		return (z * 64 + y) * 64 + x;
	endfunction

	function automatic int eff(int unsigned v, int unsigned m);
		return (v > m) ? m : v;
	endfunction

	function automatic bit out_of_range(int x, int y, int z);
		return x >= eff(dim_x, 64) || y >= eff(dim_y, 64) || z >= eff(dim_z, 16);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root, b;
		root = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	// first unwritten voxel in the clipped window, or -1 when the window is fully written
	function automatic int first_hole(int x, int y, int z);
		int sx, sy, sz, r;
		sx = eff(dim_x, 64); sy = eff(dim_y, 64); sz = eff(dim_z, 16); r = eff(win_r, 3);
		for (int k = z - r; k <= z + r; k++)
			for (int j = y - r; j <= y + r; j++)
				for (int i = x - r; i <= x + r; i++)
					if (k >= 0 && k < sz && j >= 0 && j < sy && i >= 0 && i < sx)
						if (!voxel_set[vaddr(i, j, k)]) return vaddr(i, j, k);
		return -1;
	endfunction

	function automatic box_res_t box_predict(stim_row_t t);
		box_res_t res;
		longint unsigned acc, cnt, d, sq, v;
		int sx, sy, sz, r;
		sx = eff(dim_x, 64); sy = eff(dim_y, 64); sz = eff(dim_z, 16); r = eff(win_r, 3);
		res = '{0, 0, 0};
		acc = 0; cnt = 0;
		if (t.c == lbx_pkg::CMD_BAD || out_of_range(t.x, t.y, t.z)) begin
			res.status = 1'b1;
			return res;
		end
		if (t.c == lbx_pkg::CMD_WRITE) begin
			voxels[vaddr(t.x, t.y, t.z)] = t.smp;
			voxel_set[vaddr(t.x, t.y, t.z)] = 1'b1;
			return res;
		end
		for (int k = int'(t.z) - r; k <= int'(t.z) + r; k++)
			for (int j = int'(t.y) - r; j <= int'(t.y) + r; j++)
				for (int i = int'(t.x) - r; i <= int'(t.x) + r; i++) begin
					if (k < 0 || k >= sz || j < 0 || j >= sy || i < 0 || i >= sx) continue;
					cnt++;
					if (t.c == lbx_pkg::CMD_MEAN) begin
						acc += voxels[vaddr(i, j, k)];
					end else begin
						v = longint'(voxels[vaddr(i, j, k)]) << 8;
						d = (v >= t.cm) ? v - t.cm : t.cm - v;
						sq = d * d;
						acc = (acc > ~64'd0 - sq) ? ~64'd0 : acc + sq;
					end
				end
		v = (t.c == lbx_pkg::CMD_MEAN) ? (acc << 8) / cnt : int_sqrt(acc / cnt);
		res.value = (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
		res.count = cnt[8:0];
		return res;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
	endtask

	// sender
	int send_n = 0;
	task automatic send(stim_row_t t);
		box_res_t pred;
		int gap;
		gap = ((send_n / 32) % 4 == 3) ? 0 : $urandom_range(0, 16);
		send_n++;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		cmd <= t.c; pos_x <= t.x; pos_y <= t.y; pos_z <= t.z;
		sample <= t.smp; center_mean <= t.cm;
		do @(posedge clk); while (full !== 1'b0);
		pred = box_predict(t);
		pending_q.push_back(t.typed ? t.res : pred);
	endtask

	task automatic idle_push();
		push <= 1'b0;
		@(posedge clk);
	endtask

	task automatic cfg_write(lbx_pkg::reg_idx_t idx, logic [lbx_pkg::CFG_W-1:0] d);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			lbx_pkg::REG_SIZE_X: dim_x = d & 7'h7F;
			lbx_pkg::REG_SIZE_Y: dim_y = d & 7'h7F;
			lbx_pkg::REG_SIZE_Z: dim_z = d & 7'h1F;
			lbx_pkg::REG_RADIUS: win_r = d & 7'h03;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic stim_row_t mk(lbx_pkg::cmd_t c, int x, int y, int z, int s, int m,
		bit typed, int v, int n, int st);
		stim_row_t t;
		t.c = c; t.x = 6'(x); t.y = 6'(y); t.z = 4'(z); t.smp = 16'(s); t.cm = 24'(m);
		t.typed = typed; t.res = '{24'(v), 9'(n), 1'(st)};
		return t;
	endfunction

	// random item around a focus point; a query on a window with holes becomes a write
	function automatic stim_row_t rand_item(int fx, int fy, int fz);
		stim_row_t t;
		int roll, hole;
		roll = $urandom_range(0, 99);
		t.typed = 1'b0;
		t.res = '{0, 0, 0};
		if (roll < 6) begin
			t.x = 6'($urandom); t.y = 6'($urandom); t.z = 4'($urandom);
		end else begin
			t.x = 6'(fx + $urandom_range(0, 3));
			t.y = 6'(fy + $urandom_range(0, 3));
			t.z = 4'(fz + $urandom_range(0, 2));
		end
		case ($urandom_range(0, 3))
			0: t.smp = 16'hFFFF;
			1: t.smp = 16'h0000;
			default: t.smp = 16'($urandom);
		endcase
		t.cm = ($urandom_range(0, 1)) ? 24'($urandom) :
			24'({t.smp, 8'h00} + $urandom_range(0, 600) - 300);
		if (roll < 40) t.c = lbx_pkg::CMD_WRITE;
		else if (roll < 67) t.c = lbx_pkg::CMD_MEAN;
		else if (roll < 94) t.c = lbx_pkg::CMD_SD;
		else t.c = lbx_pkg::CMD_BAD;
		if ((t.c == lbx_pkg::CMD_MEAN || t.c == lbx_pkg::CMD_SD) &&
			!out_of_range(t.x, t.y, t.z)) begin
			hole = first_hole(t.x, t.y, t.z);
			if (hole >= 0) begin
				t.c = lbx_pkg::CMD_WRITE;
				t.x = 6'(hole % 64); t.y = 6'((hole / 64) % 64); t.z = 4'(hole / 4096);
			end
		end
		return t;
	endfunction

	// receiver
	initial begin
		int gap, n;
		box_res_t want;
		n = 0;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = ((n / 32) % 4 == 1) ? 0 : $urandom_range(0, 16);
			n++;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0);
			if (pending_q.size() == 0) begin
				report("unexpected result", value, 0);
			end else begin
				want = pending_q.pop_front();
				if (value !== want.value) report("value", value, want.value);
				if (count !== want.count) report("count", count, want.count);
				if (status !== want.status) report("status", status, want.status);
			end
		end
	end

	// watchdog on cycles without any transaction
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	stim_row_t directed [$];
	int phase_cfg [6][4] = '{
		'{5, 4, 3, 2}, '{1, 1, 1, 0}, '{127, 100, 31, 3},
		'{0, 64, 16, 1}, '{64, 64, 16, 0}, '{9, 17, 2, 3}
	};

	initial begin
		int fx, fy, fz;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner windows at reset settings, radius 1: eight voxels each
		for (int i = 0; i < 8; i++)
			directed.push_back(mk(lbx_pkg::CMD_WRITE, i[0], i[1], i[2], 16'hFFFF, 0,
				1, 0, 0, 0));
		directed.push_back(mk(lbx_pkg::CMD_MEAN, 0, 0, 0, 0, 0, 1, 24'hFFFF00, 8, 0));
		directed.push_back(mk(lbx_pkg::CMD_SD, 0, 0, 0, 0, 0, 1, 24'hFFFF00, 8, 0));
		directed.push_back(mk(lbx_pkg::CMD_SD, 0, 0, 0, 0, 24'hFFFF00, 1, 0, 8, 0));
		directed.push_back(mk(lbx_pkg::CMD_BAD, 5, 5, 5, 16'h1234, 24'h123456, 1, 0, 0, 1));
		for (int i = 0; i < 8; i++)
			directed.push_back(mk(lbx_pkg::CMD_WRITE, 63 - i[0], 63 - i[1], 15 - i[2], 0, 0,
				1, 0, 0, 0));
		directed.push_back(mk(lbx_pkg::CMD_MEAN, 63, 63, 15, 0, 0, 1, 0, 8, 0));
		directed.push_back(mk(lbx_pkg::CMD_SD, 63, 63, 15, 0, 24'hFFFFFF, 1, 24'hFFFFFF,
			8, 0));
		directed.push_back(mk(lbx_pkg::CMD_SD, 0, 0, 0, 0, 24'h7FFF80, 0, 0, 0, 0));
		foreach (directed[i]) send(directed[i]);
		idle_push();

		foreach (phase_cfg[p]) begin
			drain();
			cfg_write(lbx_pkg::REG_SIZE_X, lbx_pkg::CFG_W'(phase_cfg[p][0]));
			cfg_write(lbx_pkg::REG_SIZE_Y, lbx_pkg::CFG_W'(phase_cfg[p][1]));
			cfg_write(lbx_pkg::REG_SIZE_Z, lbx_pkg::CFG_W'(phase_cfg[p][2]));
			cfg_write(lbx_pkg::REG_RADIUS, lbx_pkg::CFG_W'(phase_cfg[p][3]));
			fx = $urandom_range(0, (eff(dim_x, 64) > 4) ? eff(dim_x, 64) - 4 : 0);
			fy = $urandom_range(0, (eff(dim_y, 64) > 4) ? eff(dim_y, 64) - 4 : 0);
			fz = $urandom_range(0, (eff(dim_z, 16) > 3) ? eff(dim_z, 16) - 3 : 0);
			// long result stall once so the input side backs up
			if (p == 0) hold_req = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) send(rand_item(fx, fy, fz));
			idle_push();
		end

		drain();
		if (pending_q.size() != 0) report("missing results", pending_q.size(), 0);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
